/* hdl/bitmap_run_page_allocator_assert.svh */
// assertion macros for the page allocator
`ifndef BITMAP_RUN_PAGE_ALLOCATOR_ASSERT_SVH
`define BITMAP_RUN_PAGE_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

`define BRA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

`define BRA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`else

`define BRA_ASSERT_IMP(label, ante, cons)

`define BRA_ASSERT_NXT(label, ante, cons)

`endif

`endif

/* hdl/bra_pkg.sv */
`default_nettype none

package bra_pkg;

  localparam int NUM_PAGES = 4096;
  localparam int MAX_RUN   = 64;
  localparam int WORD_BITS = 64;
  localparam int MAP_WORDS = NUM_PAGES / WORD_BITS;
  localparam int WORD_AW   = $clog2(MAP_WORDS);
  localparam int BIT_AW    = $clog2(WORD_BITS);
  localparam int PAGE_W    = WORD_AW + BIT_AW;
  localparam int COUNT_W   = 7;
  localparam int CFG_IDX_W = 3;
  localparam int RUN_LVLS  = BIT_AW + 1;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] ZN_DMA    = 2'd0;
  localparam logic [1:0] ZN_NORMAL = 2'd1;
  localparam logic [1:0] ZN_HIGH   = 2'd2;
  localparam logic [1:0] ZN_BAD    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_ZONE  = 2'd1;
  localparam logic [1:0] ST_NO_SPACE  = 2'd2;
  localparam logic [1:0] ST_BAD_COUNT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_DMA_FIRST    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DMA_LAST     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_FIRST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_LAST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_FIRST   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LAST    = 3'd5;

  typedef enum logic [2:0] {
    RD_NONE  = 3'd0,
    RD_FIRST = 3'd1,
    RD_NEXT  = 3'd2,
    RD_A     = 3'd3,
    RD_B     = 3'd4
  } rd_sel_t;

  typedef struct packed {
    logic       latch_req;
    logic       scan_init;
    logic       scan_eval;
    logic       scan_adv;
    logic       take_hit;
    logic       load_free;
    rd_sel_t    rd_sel;
    logic       wr_a;
    logic       wr_b;
    logic       load_out;
    logic [1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic bad_zone;
    logic alloc_cnt_bad;
    logic free_cnt_bad;
    logic zone_empty;
    logic hit_any;
    logic word_last;
    logic need_b;
  } dp_stat_t;

endpackage

`default_nettype wire

/* hdl/bra_datapath.sv */
`default_nettype none

module bra_datapath
  import bra_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_req_type,
  input  logic [1:0]           in_zone,
  input  logic [COUNT_W-1:0]   in_page_count,
  input  logic [PAGE_W-1:0]    in_start_page,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PAGE_W-1:0]    cfg_data,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  output logic [1:0]           out_status,
  output logic [PAGE_W-1:0]    out_page_index
);

  logic [PAGE_W-1:0] dma_first_r, dma_last_r, normal_first_r, normal_last_r;
  logic [PAGE_W-1:0] high_first_r, high_last_r;

  logic               req_type_r;
  logic [1:0]         zone_r;
  logic [COUNT_W-1:0] count_r;
  logic [PAGE_W-1:0]  start_r;

  logic [PAGE_W-1:0] first_sel, last_sel;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] vld_r;
  logic [WORD_BITS-1:0] rdata_r;
  logic                 rd_vld_r;
  logic [WORD_AW-1:0]   rd_addr;
  logic                 rd_en;
  logic [WORD_AW-1:0]   wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic                 wr_en;
  logic [WORD_BITS-1:0] cur_used;

  logic [WORD_AW-1:0]     word_r;
  logic [WORD_BITS-1:0]   prev_free_r;
  logic [WORD_BITS-1:0]   hit_r;
  logic [PAGE_W-1:0]      run_start_r;
  logic [WORD_BITS-1:0]   lo_mask, hi_mask, free_w;
  logic [2*WORD_BITS-1:0] dbl [RUN_LVLS];
  logic [2:0]             lg;
  logic [COUNT_W-1:0]     rem;
  logic [2*WORD_BITS-1:0] runv;
  logic [BIT_AW-1:0]      hit_pos;
  logic [PAGE_W-1:0]      end_page;

  logic [WORD_BITS-1:0]   ones_k;
  logic [2*WORD_BITS-1:0] run_mask;
  logic [WORD_BITS-1:0]   half_mask;

  logic [1:0]        out_status_r;
  logic [PAGE_W-1:0] out_page_r;

  // zone registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dma_first_r    <= '0;
      dma_last_r     <= '0;
      normal_first_r <= '0;
      normal_last_r  <= '1;
      high_first_r   <= '0;
      high_last_r    <= '1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DMA_FIRST:    dma_first_r    <= cfg_data;
        CFG_DMA_LAST:     dma_last_r     <= cfg_data;
        CFG_NORMAL_FIRST: normal_first_r <= cfg_data;
        CFG_NORMAL_LAST:  normal_last_r  <= cfg_data;
        CFG_HIGH_FIRST:   high_first_r   <= cfg_data;
        CFG_HIGH_LAST:    high_last_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_type_r <= in_req_type;
      zone_r     <= in_zone;
      count_r    <= in_page_count;
      start_r    <= in_start_page;
    end
  end

  always_comb begin
    case (zone_r)
      ZN_DMA: begin
        first_sel = dma_first_r;
        last_sel  = dma_last_r;
      end
      ZN_NORMAL: begin
        first_sel = normal_first_r;
        last_sel  = normal_last_r;
      end
      default: begin
        first_sel = high_first_r;
        last_sel  = high_last_r;
      end
    endcase
  end

  // bitmap store, entries never written read as all free
  always_comb begin
    case (cmd.rd_sel)
      RD_FIRST: rd_addr = first_sel[PAGE_W-1:BIT_AW];
      RD_NEXT:  rd_addr = word_r + WORD_AW'(1);
      RD_A:     rd_addr = run_start_r[PAGE_W-1:BIT_AW];
      RD_B:     rd_addr = run_start_r[PAGE_W-1:BIT_AW] + WORD_AW'(1);
      default:  rd_addr = '0;
    endcase
  end

  assign rd_en = (cmd.rd_sel != RD_NONE);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign cur_used = rd_vld_r ? rdata_r : '0;

  // free window of previous and current word, run detection by doubling
  assign lo_mask = (word_r == first_sel[PAGE_W-1:BIT_AW]) ?
                   ({WORD_BITS{1'b1}} << first_sel[BIT_AW-1:0]) : {WORD_BITS{1'b1}};
  assign hi_mask = (word_r == last_sel[PAGE_W-1:BIT_AW]) ?
                   ({WORD_BITS{1'b1}} >> (BIT_AW'(WORD_BITS - 1) - last_sel[BIT_AW-1:0])) :
                   {WORD_BITS{1'b1}};
  assign free_w  = ~cur_used & lo_mask & hi_mask;

  always_comb begin
    dbl[0] = {free_w, prev_free_r};
    for (int j = 1; j < RUN_LVLS; j++) begin
      dbl[j] = dbl[j-1] & (dbl[j-1] << (1 << (j - 1)));
    end
  end

  always_comb begin
    lg = '0;
    for (int j = 0; j < RUN_LVLS; j++) begin
      if (count_r[j]) begin
        lg = 3'(j);
      end
    end
  end

  assign rem  = count_r - (COUNT_W'(1) << lg);
  assign runv = dbl[lg] & (dbl[lg] << rem[BIT_AW-1:0]);

  always_comb begin
    hit_pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (hit_r[i]) begin
        hit_pos = BIT_AW'(i);
      end
    end
  end

  assign end_page = {word_r, hit_pos};

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      word_r      <= first_sel[PAGE_W-1:BIT_AW];
      prev_free_r <= '0;
    end else begin
      if (cmd.scan_eval) begin
        hit_r       <= runv[2*WORD_BITS-1:WORD_BITS];
        prev_free_r <= free_w;
      end
      if (cmd.scan_adv) begin
        word_r <= word_r + WORD_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_hit) begin
      run_start_r <= end_page + PAGE_W'(1) - PAGE_W'(count_r);
    end else if (cmd.load_free) begin
      run_start_r <= start_r;
    end
  end

  // read-modify-write of the one or two words a run touches
  assign ones_k   = {WORD_BITS{1'b1}} >> (COUNT_W'(WORD_BITS) - count_r);
  assign run_mask = {{WORD_BITS{1'b0}}, ones_k} << run_start_r[BIT_AW-1:0];

  assign half_mask = cmd.wr_b ? run_mask[2*WORD_BITS-1:WORD_BITS] : run_mask[WORD_BITS-1:0];
  assign wr_en     = cmd.wr_a | cmd.wr_b;
  assign wr_addr   = run_start_r[PAGE_W-1:BIT_AW] + (cmd.wr_b ? WORD_AW'(1) : WORD_AW'(0));
  assign wr_data   = (req_type_r == REQ_ALLOC) ? (cur_used | half_mask) :
                                                 (cur_used & ~half_mask);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= cmd.status;
      out_page_r   <= (cmd.status == ST_OK && req_type_r == REQ_ALLOC) ? run_start_r : '0;
    end
  end

  assign out_status     = out_status_r;
  assign out_page_index = out_page_r;

  assign stat.is_free       = (req_type_r == REQ_FREE);
  assign stat.bad_zone      = (zone_r == ZN_BAD);
  assign stat.alloc_cnt_bad = (count_r == '0) || (count_r > COUNT_W'(MAX_RUN));
  assign stat.free_cnt_bad  = (count_r == '0) || (count_r >= COUNT_W'(MAX_RUN));
  assign stat.zone_empty    = (first_sel > last_sel);
  assign stat.hit_any       = |hit_r;
  assign stat.word_last     = (word_r == last_sel[PAGE_W-1:BIT_AW]);
  assign stat.need_b        = (|run_mask[2*WORD_BITS-1:WORD_BITS]) &&
                              (run_start_r[PAGE_W-1:BIT_AW] != {WORD_AW{1'b1}});

endmodule

`default_nettype wire

/* hdl/bra_ctrl.sv */
`default_nettype none

module bra_ctrl
  import bra_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_CHECK    = 8'b0000_0010,
    S_SCAN_EV  = 8'b0000_0100,
    S_SCAN_ENC = 8'b0000_1000,
    S_MOD_RD   = 8'b0001_0000,
    S_MOD_WA   = 8'b0010_0000,
    S_MOD_WB   = 8'b0100_0000,
    S_FIN      = 8'b1000_0000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] status_r, status_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      status_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.rd_sel    = RD_NONE;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_req = 1'b1;
          state_nxt     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.is_free) begin
          if (stat.free_cnt_bad) begin
            status_nxt = ST_BAD_COUNT;
            state_nxt  = S_FIN;
          end else begin
            cmd.load_free = 1'b1;
            state_nxt     = S_MOD_RD;
          end
        end else if (stat.bad_zone) begin
          status_nxt = ST_BAD_ZONE;
          state_nxt  = S_FIN;
        end else if (stat.alloc_cnt_bad) begin
          status_nxt = ST_BAD_COUNT;
          state_nxt  = S_FIN;
        end else if (stat.zone_empty) begin
          status_nxt = ST_NO_SPACE;
          state_nxt  = S_FIN;
        end else begin
          cmd.scan_init = 1'b1;
          cmd.rd_sel    = RD_FIRST;
          state_nxt     = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        cmd.scan_eval = 1'b1;
        state_nxt     = S_SCAN_ENC;
      end
      S_SCAN_ENC: begin
        if (stat.hit_any) begin
          cmd.take_hit = 1'b1;
          state_nxt    = S_MOD_RD;
        end else if (stat.word_last) begin
          status_nxt = ST_NO_SPACE;
          state_nxt  = S_FIN;
        end else begin
          cmd.scan_adv = 1'b1;
          cmd.rd_sel   = RD_NEXT;
          state_nxt    = S_SCAN_EV;
        end
      end
      S_MOD_RD: begin
        cmd.rd_sel = RD_A;
        state_nxt  = S_MOD_WA;
      end
      S_MOD_WA: begin
        cmd.wr_a   = 1'b1;
        status_nxt = ST_OK;
        if (stat.need_b) begin
          cmd.rd_sel = RD_B;
          state_nxt  = S_MOD_WB;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_MOD_WB: begin
        cmd.wr_b  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.status = status_r;
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* hdl/bitmap_run_page_allocator.sv */
// Contiguous page-run allocator over a 4096-page used bitmap (64 words of 64 bits).
// Input channel (in_valid/in_ready): one request per transfer, alloc or free.
// Output channel (out_valid/out_ready): exactly one status/page result per request.
// Config channel (cfg_valid/cfg_ready): zone first/last page registers, always ready;
// write it only while no request is in flight.
// One request is worked on at a time; in_ready is high only while the block is idle,
// so the next input can transfer at the earliest in the cycle after a result loads.
// A rejected request goes straight to its result; a free rewrites one or two bitmap
// words; an alloc scans the zone one bitmap word at a time and, when a run is granted,
// rewrites one or two words, or else returns no space after the zone's last word.
// The result sits in an output register; while the receiver stalls the block still
// takes the next request and works on it, then waits with its result until the
// register is emptied.
// Reset (rst_n low, synchronous) marks every page free at once through per-word
// valid bits, loads the zone reset values and drops any pending result; the block
// takes requests in the first cycle after reset.
`default_nettype none

`include "bitmap_run_page_allocator_assert.svh"

module bitmap_run_page_allocator
  import bra_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_req_type,
  input  logic [1:0]           in_zone,
  input  logic [COUNT_W-1:0]   in_page_count,
  input  logic [PAGE_W-1:0]    in_start_page,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [PAGE_W-1:0]    out_page_index,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PAGE_W-1:0]    cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  bra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bra_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_req_type    (in_req_type),
    .in_zone        (in_zone),
    .in_page_count  (in_page_count),
    .in_start_page  (in_start_page),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .stat           (stat),
    .out_status     (out_status),
    .out_page_index (out_page_index)
  );

  // busy after every input transfer
  `BRA_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // a pending result is never overwritten
  `BRA_ASSERT_IMP(a_no_overwrite, cmd.load_out, !out_valid || out_ready)
  // only a granted run carries a page number
  `BRA_ASSERT_IMP(a_page_zero_on_fail, out_valid && out_status != ST_OK, out_page_index == '0)
  // no bitmap write while a result is being loaded
  `BRA_ASSERT_IMP(a_no_write_on_load, cmd.load_out, !cmd.wr_a && !cmd.wr_b)

endmodule

`default_nettype wire

/* dv/page_run_checker.sv */
module page_run_checker
  import bra_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_req_type,
  input  logic [1:0]           in_zone,
  input  logic [COUNT_W-1:0]   in_page_count,
  input  logic [PAGE_W-1:0]    in_start_page,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [1:0]           out_status,
  input  logic [PAGE_W-1:0]    out_page_index,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PAGE_W-1:0]    cfg_data,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    logic [1:0]        status;
    logic [PAGE_W-1:0] page;
  } grant_t;

  logic [NUM_PAGES-1:0] used_pages;
  logic [PAGE_W-1:0]    zone_first [3];
  logic [PAGE_W-1:0]    zone_last [3];
  grant_t               grant_q [$];
  grant_t               want;

  // allocate or free a run against the shadow bitmap
  function automatic grant_t predict_grant(logic req, logic [1:0] zone,
                                           logic [COUNT_W-1:0] cnt,
                                           logic [PAGE_W-1:0] start);
    grant_t g;
    int     first;
    int     last;
    int     run;
    int     hit;
    g.status = ST_OK;
    g.page   = '0;
    if (req == REQ_FREE) begin
      if (cnt == 0 || cnt >= MAX_RUN) begin
        g.status = ST_BAD_COUNT;
      end else begin
        for (int i = 0; i < cnt; i++) begin
          if (start + i < NUM_PAGES) used_pages[start + i] = 1'b0;
        end
      end
    end else if (zone == ZN_BAD) begin
      g.status = ST_BAD_ZONE;
    end else if (cnt == 0 || cnt > MAX_RUN) begin
      g.status = ST_BAD_COUNT;
    end else begin
      first = int'(zone_first[zone]);
      last  = int'(zone_last[zone]);
      run   = 0;
      hit   = -1;
      g.status = ST_NO_SPACE;
      if (first <= last) begin
        for (int pg = first; pg <= last && hit < 0; pg++) begin
          if (pg >= NUM_PAGES || used_pages[pg]) begin
            run = 0;
          end else begin
            run++;
            if (run == cnt) hit = pg + 1 - cnt;
          end
        end
      end
      if (hit >= 0) begin
        for (int i = 0; i < cnt; i++) used_pages[hit + i] = 1'b1;
        g.status = ST_OK;
        g.page   = hit[PAGE_W-1:0];
      end
    end
    return g;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      used_pages = '0;
      zone_first[ZN_DMA]    = '0;
      zone_last[ZN_DMA]     = '0;
      zone_first[ZN_NORMAL] = '0;
      zone_last[ZN_NORMAL]  = '1;
      zone_first[ZN_HIGH]   = '0;
      zone_last[ZN_HIGH]    = '1;
      grant_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DMA_FIRST:    zone_first[ZN_DMA]    = cfg_data;
          CFG_DMA_LAST:     zone_last[ZN_DMA]     = cfg_data;
          CFG_NORMAL_FIRST: zone_first[ZN_NORMAL] = cfg_data;
          CFG_NORMAL_LAST:  zone_last[ZN_NORMAL]  = cfg_data;
          CFG_HIGH_FIRST:   zone_first[ZN_HIGH]   = cfg_data;
          CFG_HIGH_LAST:    zone_last[ZN_HIGH]    = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (grant_q.size() == 0) begin
          $error("result transfer with no request outstanding");
          fail_count++;
        end else begin
          want = grant_q.pop_front();
          if (out_status !== want.status) begin
            $error("out_status expected %0d actual %0d", want.status, out_status);
            fail_count++;
          end
          if (out_page_index !== want.page) begin
            $error("out_page_index expected %0d actual %0d", want.page, out_page_index);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        grant_q.push_back(predict_grant(in_req_type, in_zone, in_page_count,
                                        in_start_page));
      end
    end
    pending = grant_q.size();
  end

endmodule

/* dv/tb_top.sv */
module tb_top;
  import bra_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_req_type;
  logic [1:0]           in_zone;
  logic [COUNT_W-1:0]   in_page_count;
  logic [PAGE_W-1:0]    in_start_page;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           out_status;
  logic [PAGE_W-1:0]    out_page_index;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PAGE_W-1:0]    cfg_data;
  int                   fail_count;
  int                   pending;
  bit                   tx_calm = 1'b0;
  bit                   rx_calm = 1'b0;
  bit                   hold_rx = 1'b0;
  int                   zf [3];
  int                   zl [3];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  bitmap_run_page_allocator u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_zone        (in_zone),
    .in_page_count  (in_page_count),
    .in_start_page  (in_start_page),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_page_index (out_page_index),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  page_run_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_zone        (in_zone),
    .in_page_count  (in_page_count),
    .in_start_page  (in_start_page),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_page_index (out_page_index),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  task automatic send_req(logic req, logic [1:0] zone, int cnt, int start);
    while (!tx_calm && $urandom_range(99) < 30) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_zone       <= zone;
    in_page_count <= COUNT_W'(cnt);
    in_start_page <= PAGE_W'(start);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_tx();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // drain every outstanding result before touching the zone registers
  task automatic settle();
    idle_tx();
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= PAGE_W'(data);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_zones(int d0, int d1, int n0, int n1, int h0, int h1);
    write_reg(CFG_DMA_FIRST, d0);
    write_reg(CFG_DMA_LAST, d1);
    write_reg(CFG_NORMAL_FIRST, n0);
    write_reg(CFG_NORMAL_LAST, n1);
    write_reg(CFG_HIGH_FIRST, h0);
    write_reg(CFG_HIGH_LAST, h1);
    zf[ZN_DMA]    = d0;
    zl[ZN_DMA]    = d1;
    zf[ZN_NORMAL] = n0;
    zl[ZN_NORMAL] = n1;
    zf[ZN_HIGH]   = h0;
    zl[ZN_HIGH]   = h1;
  endtask

  // mostly short ranges so zones fill up and fragment; some empty or reversed
  task automatic pick_range(output int f, output int l);
    f = $urandom_range(4095);
    if ($urandom_range(9) == 0) l = $urandom_range(f);
    else l = f + $urandom_range(40, 400);
    if (l > 4095) l = 4095;
  endtask

  task automatic random_zones();
    int d0, d1, n0, n1, h0, h1;
    pick_range(d0, d1);
    pick_range(n0, n1);
    pick_range(h0, h1);
    set_zones(d0, d1, n0, n1, h0, h1);
  endtask

  task automatic random_item();
    int   r;
    int   z;
    int   c;
    int   s;
    int   span;
    logic req;
    req = ($urandom_range(99) < 55) ? REQ_ALLOC : REQ_FREE;
    r   = $urandom_range(99);
    if (r < 5) c = $urandom_range(1) ? 0 : $urandom_range(64, 127);
    else if (r < 12) c = (req == REQ_ALLOC) ? MAX_RUN : MAX_RUN - 1;
    else if (r < 35) c = $urandom_range(1, MAX_RUN - 1);
    else c = $urandom_range(1, 12);
    z = $urandom_range(2);
    if (req == REQ_ALLOC) begin
      if ($urandom_range(99) < 5) z = int'(ZN_BAD);
      s = $urandom_range(4095);
    end else begin
      // free mostly inside a zone so it hits used pages
      span = zl[z] - zf[z];
      if (span < 0 || $urandom_range(9) == 0) s = $urandom_range(4095);
      else s = zf[z] + $urandom_range(span);
      z = $urandom_range(3);
    end
    send_req(req, z[1:0], c, s);
  endtask

  // receiver
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        hold_rx = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= rx_calm || ($urandom_range(99) >= 30);
      end
    end
  end

  // watchdog: cycles with no transfer on any channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = REQ_ALLOC;
    in_zone       = ZN_DMA;
    in_page_count = '0;
    in_start_page = '0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_DMA_FIRST;
    cfg_data      = '0;
    zf[ZN_DMA]    = 0;
    zl[ZN_DMA]    = 0;
    zf[ZN_NORMAL] = 0;
    zl[ZN_NORMAL] = 4095;
    zf[ZN_HIGH]   = 0;
    zl[ZN_HIGH]   = 4095;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset zones
    send_req(REQ_ALLOC, ZN_NORMAL, 1, 0);
    send_req(REQ_ALLOC, ZN_NORMAL, 64, 0);
    send_req(REQ_ALLOC, ZN_HIGH, 63, 0);
    send_req(REQ_ALLOC, ZN_DMA, 1, 0);
    send_req(REQ_ALLOC, ZN_BAD, 0, 0);
    send_req(REQ_ALLOC, ZN_NORMAL, 0, 0);
    send_req(REQ_ALLOC, ZN_NORMAL, 65, 0);
    send_req(REQ_ALLOC, ZN_HIGH, 127, 4095);
    send_req(REQ_FREE, ZN_DMA, 0, 0);
    send_req(REQ_FREE, ZN_DMA, 64, 0);
    send_req(REQ_FREE, ZN_BAD, 127, 4095);
    send_req(REQ_FREE, ZN_DMA, 1, 0);
    send_req(REQ_ALLOC, ZN_DMA, 1, 0);
    send_req(REQ_FREE, ZN_NORMAL, 63, 4090);
    send_req(REQ_FREE, ZN_HIGH, 5, 10);
    send_req(REQ_FREE, ZN_HIGH, 5, 10);
    send_req(REQ_ALLOC, ZN_NORMAL, 5, 0);

    // directed, single-page, reversed and top-of-map zones
    settle();
    set_zones(4095, 4095, 50, 10, 4032, 4095);
    write_reg(CFG_SPARE, 123);
    send_req(REQ_ALLOC, ZN_DMA, 1, 0);
    send_req(REQ_ALLOC, ZN_DMA, 2, 0);
    send_req(REQ_ALLOC, ZN_NORMAL, 1, 0);
    send_req(REQ_ALLOC, ZN_HIGH, 64, 0);
    send_req(REQ_FREE, ZN_HIGH, 1, 4095);
    send_req(REQ_ALLOC, ZN_HIGH, 64, 0);
    send_req(REQ_ALLOC, ZN_HIGH, 1, 0);

    for (int p = 0; p < 7; p++) begin
      settle();
      case (p)
        0: set_zones(0, 191, 192, 511, 3904, 4095);
        6: set_zones(0, 4095, 4095, 4095, 4000, 100);
        default: random_zones();
      endcase
      tx_calm = (p == 4);
      rx_calm = (p == 4);
      for (int i = 0; i < 200; i++) begin
        if (p == 2 && i == 20) hold_rx = 1'b1;
        if (p == 3 && i == 100) begin
          idle_tx();
          while (pending != 0) @(negedge clk);
        end
        random_item();
      end
    end

    settle();
    repeat (150) @(negedge clk);
    if (fail_count == 0 && pending == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
